// File: hw/rtl/lfc_pkg.sv
// ============================================================================
// lfc_pkg
// Shared types and constants for the line full convolution unit.
// ============================================================================
package lfc_pkg;

  // Kernel and field sizes.
  localparam int MAX_TAPS    = 7;
  localparam int NUM_COEF    = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int PIXEL_W     = 8;
  localparam int COEF_W      = 16;
  localparam int TAPS_W      = 3;
  localparam int PROD_W      = 25;
  localparam int FILT_W      = 27;
  localparam int POS_W       = 9;
  localparam int INDEX_W     = 3;

  // Output positions stop counting here until the line ends.
  localparam logic [POS_W-1:0] POS_LIMIT = 9'd261;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    REG_TAP_COUNT = 3'd0,
    REG_COEF_0    = 3'd1,
    REG_COEF_1    = 3'd2,
    REG_COEF_2    = 3'd3,
    REG_COEF_3    = 3'd4,
    REG_COEF_4    = 3'd5,
    REG_COEF_5    = 3'd6,
    REG_COEF_6    = 3'd7
  } reg_index_t;

  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

  // Register values after reset: a 1, 0, -1 kernel over three taps.
  localparam logic [TAPS_W-1:0] TAP_COUNT_RESET = 3'd3;
  localparam coef_bank_t COEF_RESET = {16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                       16'hFFFF, 16'h0000, 16'h0001};

  // One accepted input sample as held in the queue.
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               end_of_line;
  } item_t;

  // One result to compute: the sample window and its bookkeeping.
  typedef struct packed {
    logic [NUM_COEF-1:0][PIXEL_W-1:0] sample;
    logic [POS_W-1:0]                 position;
    logic                             last;
  } window_t;

endpackage

// File: hw/rtl/lfc_front.sv
// ============================================================================
// lfc_front
// Input side: accepts sample transactions and holds them in a short queue.
// ============================================================================
module lfc_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lfc_pkg::PIXEL_W-1:0]  pixel,
  input  logic                         end_of_line,
  output logic                         q_valid,
  output lfc_pkg::item_t               q_item,
  input  logic                         q_pop
);

  localparam int DEPTH = lfc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lfc_pkg::item_t     entry [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;

  // The queue stalls the upstream side only when every entry is taken.
  assign in_stall = (count == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = entry[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= '{pixel: pixel, end_of_line: end_of_line};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/lfc_seq.sv
// ============================================================================
// lfc_seq
// Back-end sequencer: keeps the sample history and issues one window per
// result, including the zero-padded tail at the end of each line.
// ============================================================================
module lfc_seq #(
  parameter int MAX_TAPS = lfc_pkg::MAX_TAPS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lfc_pkg::TAPS_W-1:0]   tap_count,
  input  logic                         q_valid,
  input  lfc_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         win_valid,
  output lfc_pkg::window_t             win,
  input  logic                         win_ready
);

  localparam int HIST_DEPTH = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int NUM_COEF   = lfc_pkg::NUM_COEF;
  localparam int TAPS_W     = lfc_pkg::TAPS_W;
  localparam int PIXEL_W    = lfc_pkg::PIXEL_W;

  logic [PIXEL_W-1:0]       hist [HIST_DEPTH];
  logic [PIXEL_W-1:0]       hist_ext [NUM_COEF-1];
  logic [lfc_pkg::POS_W-1:0] position;
  logic                     tail_active;
  logic [TAPS_W-1:0]        tail_left;
  logic [TAPS_W-1:0]        taps_use;
  logic [PIXEL_W-1:0]       cur;
  logic                     last;
  logic                     issue;

  // Clamp the tap count to the range the kernel supports.
  always_comb begin
    taps_use = tap_count;
    if (tap_count == '0) begin
      taps_use = TAPS_W'(1);
    end else if (tap_count > TAPS_W'(MAX_TAPS)) begin
      taps_use = TAPS_W'(MAX_TAPS);
    end
  end

  // History padded with zeros up to the full coefficient bank.
  for (genvar k = 0; k < NUM_COEF - 1; k++) begin : g_hist_ext
    if (k < HIST_DEPTH) begin : g_real
      assign hist_ext[k] = hist[k];
    end else begin : g_pad
      assign hist_ext[k] = '0;
    end
  end

  // A window is issued from the queue head, or from the tail of a line.
  assign win_valid = tail_active || q_valid;
  assign issue     = win_valid && win_ready;
  assign q_pop     = issue && !tail_active;
  assign cur       = tail_active ? '0 : q_item.pixel;
  assign last      = tail_active ? (tail_left == TAPS_W'(1))
                                 : (q_item.end_of_line && (taps_use == TAPS_W'(1)));

  // Window: current sample first, taps beyond the count in use read zero.
  always_comb begin
    win.sample    = '0;
    win.sample[0] = cur;
    for (int j = 1; j < NUM_COEF; j++) begin
      if (TAPS_W'(j) < taps_use) begin
        win.sample[j] = hist_ext[j-1];
      end
    end
    win.position = position;
    win.last     = last;
  end

  // History, position and tail control advance once per issued window.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist[k] <= '0;
      end
      position    <= '0;
      tail_active <= 1'b0;
      tail_left   <= '0;
    end else if (issue) begin
      if (last) begin
        // The line is finished: start the next one from a clean history.
        for (int k = 0; k < HIST_DEPTH; k++) begin
          hist[k] <= '0;
        end
        position    <= '0;
        tail_active <= 1'b0;
        tail_left   <= '0;
      end else begin
        hist[0] <= cur;
        for (int k = 1; k < HIST_DEPTH; k++) begin
          hist[k] <= hist[k-1];
        end
        if (position < lfc_pkg::POS_LIMIT) begin
          position <= position + 1'b1;
        end
        if (tail_active) begin
          tail_left <= tail_left - 1'b1;
        end else if (q_item.end_of_line) begin
          tail_active <= 1'b1;
          tail_left   <= taps_use - 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/lfc_mac.sv
// ============================================================================
// lfc_mac
// Back-end datapath: a product stage and a summing stage that ends in the
// output register.
// ============================================================================
module lfc_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  lfc_pkg::coef_bank_t               coef,
  input  logic                              win_valid,
  input  lfc_pkg::window_t                  win,
  output logic                              win_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lfc_pkg::FILT_W-1:0] filtered,
  output logic [lfc_pkg::POS_W-1:0]         out_position,
  output logic                              last_result
);

  localparam int NUM_COEF = lfc_pkg::NUM_COEF;
  localparam int PROD_W   = lfc_pkg::PROD_W;
  localparam int FILT_W   = lfc_pkg::FILT_W;

  logic signed [PROD_W-1:0]  prod [NUM_COEF];
  logic [lfc_pkg::POS_W-1:0] p_position;
  logic                      p_last;
  logic                      p_valid;
  logic                      p_ready;
  logic                      o_ready;
  logic signed [FILT_W-1:0]  sum;

  // Each stage moves on when it is empty or its contents move on too.
  assign o_ready   = !out_valid || !out_stall;
  assign p_ready   = !p_valid || o_ready;
  assign win_ready = p_ready;

  // Product stage: one signed coefficient by one unsigned sample per tap.
  always_ff @(posedge clk) begin
    if (p_ready) begin
      for (int j = 0; j < NUM_COEF; j++) begin
        prod[j] <= $signed(coef[j]) * $signed({1'b0, win.sample[j]});
      end
      p_position <= win.position;
      p_last     <= win.last;
    end
  end

  // Sum of the products, sign-extended to the result width.
  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_COEF; j++) begin
      sum = sum + {{(FILT_W - PROD_W){prod[j][PROD_W-1]}}, prod[j]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (o_ready) begin
      filtered     <= sum;
      out_position <= p_position;
      last_result  <= p_last;
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid <= win_valid;
      end
      if (o_ready) begin
        out_valid <= p_valid;
      end
    end
  end

endmodule

// File: hw/rtl/line_full_convolution_unit.sv
// ============================================================================
// line_full_convolution_unit
// Full linear convolution of a pixel line with a kernel of up to seven taps.
// ============================================================================
// Each pixel transaction produces one result; a line-end pixel also produces
// a tail of further results, one fewer than the clamped tap count, with zeros
// as samples past the end, and the line's last result carries last_result.
// Pixels are taken one per cycle into a four-entry queue while it is not full,
// and the back end issues one result per cycle while the output is not
// stalled, so an ordinary pixel takes one sequencer issue and a line-end pixel
// one per tap in use. A pixel goes into a queue entry, its window from the
// queue into the product register, and its sum into the output register.
// Write the configuration registers only while no line is in flight.
module line_full_convolution_unit #(
  parameter int MAX_TAPS = lfc_pkg::MAX_TAPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_enable,
  input  logic [lfc_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [lfc_pkg::COEF_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lfc_pkg::PIXEL_W-1:0]       pixel,
  input  logic                              end_of_line,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lfc_pkg::FILT_W-1:0] filtered,
  output logic [lfc_pkg::POS_W-1:0]         out_position,
  output logic                              last_result
);

  logic [lfc_pkg::TAPS_W-1:0] tap_count;
  lfc_pkg::coef_bank_t        coef;
  logic                       q_valid;
  lfc_pkg::item_t             q_item;
  logic                       q_pop;
  logic                       win_valid;
  lfc_pkg::window_t           win;
  logic                       win_ready;
  logic [lfc_pkg::INDEX_W-1:0] coef_sel;

  assign coef_sel = cfg_index - lfc_pkg::INDEX_W'(lfc_pkg::REG_COEF_0);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= lfc_pkg::TAP_COUNT_RESET;
      coef      <= lfc_pkg::COEF_RESET;
    end else if (cfg_write_enable) begin
      if (cfg_index == lfc_pkg::REG_TAP_COUNT) begin
        tap_count <= cfg_data[lfc_pkg::TAPS_W-1:0];
      end else begin
        coef[coef_sel] <= cfg_data;
      end
    end
  end

  lfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .end_of_line (end_of_line),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  lfc_seq #(
    .MAX_TAPS (MAX_TAPS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .tap_count (tap_count),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .win_valid (win_valid),
    .win       (win),
    .win_ready (win_ready)
  );

  lfc_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .coef         (coef),
    .win_valid    (win_valid),
    .win          (win),
    .win_ready    (win_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered     (filtered),
    .out_position (out_position),
    .last_result  (last_result)
  );

endmodule

// File: hw/rtl/lfc_checker.sv
// ============================================================================
// lfc_checker
// Port-level checks on the line full convolution unit, bound to the top.
// ============================================================================
module lfc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [lfc_pkg::FILT_W-1:0] filtered,
  input  logic [lfc_pkg::POS_W-1:0]         out_position,
  input  logic                              last_result
);

  // A stalled result transaction stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered)
      && $stable(out_position) && $stable(last_result))
    else $error("stalled result changed or was withdrawn");

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // Output positions never pass the saturation point.
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_position <= lfc_pkg::POS_LIMIT)
    else $error("output position beyond its limit");

  // The sum stays within the range a seven-tap kernel can reach.
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (filtered >= -58490880) && (filtered <= 58489095))
    else $error("filtered value out of range");

endmodule

bind line_full_convolution_unit lfc_checker u_checker (.*);
